### rtl/vsz_pkg.sv
// Shared constants, types and the sine/cosine tables of the safety zone check.
`default_nettype none

package vsz_pkg;

   // Angle table size and index width
   localparam int SINE_TABLE_ENTRIES = 1024;
   localparam int TAB_IDX_W = $clog2(SINE_TABLE_ENTRIES);

   // Port and field widths
   localparam int COORD_W = 32;
   localparam int HEADING_W = 16;
   localparam int REG_W = 16;
   localparam int REQ_DATA_W = 4 * COORD_W + HEADING_W;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W = 2;

   // Datapath widths
   localparam int TRIG_W = 18;              // sine/cosine, 16 fraction bits, +-1.0 inclusive
   localparam int TRIG_MAG_W = TRIG_W - 1;
   localparam int DIFF_W = COORD_W + 1;     // point minus car center
   localparam int OFS_MAG_W = REG_W + TRIG_MAG_W;
   localparam int HN_SHIFT = 17;
   localparam int HN_W = 17;                // half-length offset, signed
   localparam int HM_W = DIFF_W + 1;        // point minus head point
   localparam int PROD_W = HM_W + HN_W;
   localparam int DOT_W = PROD_W + 1;
   localparam int HNN_W = 32;
   localparam int SQ_W = 2 * REG_W;
   localparam int THR_W = 64;

   localparam int PIPE_DEPTH = 10;

   localparam logic [REG_W-1:0] CAR_LENGTH_RESET = 16'd1024;
   localparam logic [REG_W-1:0] MARGIN_RESET = 16'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAR_LENGTH   = 2'd0,
      CSR_FRONT_MARGIN = 2'd1,
      CSR_BACK_MARGIN  = 2'd2,
      CSR_SIDE_MARGIN  = 2'd3
   } csr_index_type;

   // Load strobes for the two register stages of a square test
   typedef struct packed {
      logic load_mag;
      logic load_sq;
   } sq_adv_type;

   typedef logic signed [TRIG_W-1:0] trig_tab_type [SINE_TABLE_ENTRIES];

   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Sine of a 32-bit phase (full turn = 2^32), 16 fraction bits, rounded and saturated
   function automatic logic signed [TRIG_W-1:0] sine_q16(input logic [31:0] phase);
      logic [1:0]  quad;
      logic [63:0] f;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] r;
      quad = phase[31:30];
      f = {34'd0, phase[29:0]};
      if (quad[0]) begin
         f = ONE_Q30 - f;
      end
      x = (f * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t = ONE_Q30 - x2 / 64'd110;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s = (x * t) >> 30;
      r = (s + 64'd8192) >> 14;
      if (r > 64'd65536) begin
         r = 64'd65536;
      end
      return quad[1] ? -TRIG_W'(r) : TRIG_W'(r);
   endfunction

   // Table of the evenly spaced angles, each shifted by a phase offset
   function automatic trig_tab_type build_trig_tab(input logic [31:0] offset);
      trig_tab_type tab;
      logic [63:0]  num;
      logic [31:0]  phase;
      for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
         num = 64'(k) << 32;
         phase = 32'(num / 64'(SINE_TABLE_ENTRIES)) + offset;
         tab[k] = sine_q16(phase);
      end
      return tab;
   endfunction

   localparam trig_tab_type SIN_TAB = build_trig_tab(32'h0000_0000);
   localparam trig_tab_type COS_TAB = build_trig_tab(32'h4000_0000);

endpackage

`default_nettype wire

### rtl/vsz_sq_test.sv
// Two-stage exact test of value squared against norm_sq times margin_sq.
`default_nettype none

module vsz_sq_test (
   input  logic                             clock,
   input  vsz_pkg::sq_adv_type              adv,
   input  logic signed [vsz_pkg::DOT_W-1:0] value,
   input  logic [vsz_pkg::HNN_W-1:0]        norm_sq,
   input  logic [vsz_pkg::SQ_W-1:0]         margin_sq,
   output logic                             exceeds
);

   logic [vsz_pkg::DOT_W-1:0] mag;
   logic                      big_in;
   logic                      big_a_ff;
   logic [vsz_pkg::SQ_W-1:0]  low_a_ff;
   logic [vsz_pkg::THR_W-1:0] thr_in;
   logic [vsz_pkg::THR_W-1:0] thr_a_ff;
   logic                      big_b_ff;
   logic [vsz_pkg::THR_W-1:0] thr_b_ff;
   logic [vsz_pkg::THR_W-1:0] sq_in;
   logic [vsz_pkg::THR_W-1:0] sq_b_ff;

   always_comb begin
      mag = value[vsz_pkg::DOT_W-1] ? vsz_pkg::DOT_W'(-value) : vsz_pkg::DOT_W'(value);
      // a magnitude of 2^32 or more always exceeds the threshold
      big_in = |mag[vsz_pkg::DOT_W-1:vsz_pkg::SQ_W];
      thr_in = vsz_pkg::THR_W'(norm_sq) * vsz_pkg::THR_W'(margin_sq);
      sq_in = vsz_pkg::THR_W'(low_a_ff) * vsz_pkg::THR_W'(low_a_ff);
   end

   always_ff @(posedge clock) begin
      if (adv.load_mag) begin
         big_a_ff <= big_in;
         low_a_ff <= mag[vsz_pkg::SQ_W-1:0];
         thr_a_ff <= thr_in;
      end
      if (adv.load_sq) begin
         big_b_ff <= big_a_ff;
         thr_b_ff <= thr_a_ff;
         sq_b_ff <= sq_in;
      end
   end

   assign exceeds = big_b_ff || (sq_b_ff > thr_b_ff);

endmodule

`default_nettype wire

### rtl/vehicle_safety_zone_check_unit.sv
// Top level of the safety zone check: point against a rectangle around the car's head point.
`default_nettype none

// Answers whether a point lies in the safety rectangle around a car's head point. One
// transaction per cycle is taken on req_ and one answer comes out on rsp_ for each, in order;
// a new transaction enters every cycle while rsp_tready is high, and each answer passes through
// the register pipeline (table index, table read, offset multiply, rounding, difference,
// products, sums, two squaring stages, output). A stall on rsp_ backs up only as far as the
// pipeline is full, so bubbles inside are squeezed out first. Registers (csr_index): 0 car
// length, 1 front margin, 2 back margin, 3 side margin, all unsigned with 8 fraction bits;
// write them only while no transaction is in flight.

module vehicle_safety_zone_check_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // point_x, point_y, car_x, car_y, car_heading (lowest bits first)
   input  logic [vsz_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // inside_zone in bit 0, rest zero
   output logic [vsz_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [vsz_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vsz_pkg::REG_W-1:0]          csr_wdata
);

   // Pipeline stage positions
   localparam int ST_IDX  = 0;
   localparam int ST_TRIG = 1;
   localparam int ST_MULT = 2;
   localparam int ST_HN   = 3;
   localparam int ST_HM   = 4;
   localparam int ST_PROD = 5;
   localparam int ST_DOT  = 6;
   localparam int ST_SQA  = 7;
   localparam int ST_SQB  = 8;
   localparam int ST_OUT  = 9;

   localparam int HN_LIMIT = 1 << (vsz_pkg::REG_W - 1);
   localparam logic [vsz_pkg::HNN_W-1:0] HNN_LIMIT = vsz_pkg::HNN_W'(1) << (vsz_pkg::HNN_W - 1);
   localparam logic [vsz_pkg::OFS_MAG_W:0] HN_ROUND =
      (vsz_pkg::OFS_MAG_W + 1)'(1) << (vsz_pkg::HN_SHIFT - 1);

   // Configuration registers
   logic [vsz_pkg::REG_W-1:0] car_length_ff;
   logic [vsz_pkg::REG_W-1:0] front_margin_ff;
   logic [vsz_pkg::REG_W-1:0] back_margin_ff;
   logic [vsz_pkg::REG_W-1:0] side_margin_ff;

   // Flow control
   logic [vsz_pkg::PIPE_DEPTH-1:0] valid_ff;
   logic [vsz_pkg::PIPE_DEPTH-1:0] valid_in;
   logic [vsz_pkg::PIPE_DEPTH-1:0] load;
   logic                           in_acc;
   logic                           out_acc;

   // Stage: table index and coordinate differences
   logic signed [vsz_pkg::COORD_W-1:0] point_x;
   logic signed [vsz_pkg::COORD_W-1:0] point_y;
   logic signed [vsz_pkg::COORD_W-1:0] car_x;
   logic signed [vsz_pkg::COORD_W-1:0] car_y;
   logic [vsz_pkg::HEADING_W-1:0]      car_heading;
   logic [31:0]                        head_scaled;
   logic [vsz_pkg::TAB_IDX_W-1:0]      idx_ff;
   logic signed [vsz_pkg::DIFF_W-1:0]  dx_in;
   logic signed [vsz_pkg::DIFF_W-1:0]  dy_in;
   logic signed [vsz_pkg::DIFF_W-1:0]  dx_idx_ff;
   logic signed [vsz_pkg::DIFF_W-1:0]  dy_idx_ff;

   // Stage: sine and cosine
   logic signed [vsz_pkg::TRIG_W-1:0]  sin_ff;
   logic signed [vsz_pkg::TRIG_W-1:0]  cos_ff;
   logic signed [vsz_pkg::DIFF_W-1:0]  dx_trig_ff;
   logic signed [vsz_pkg::DIFF_W-1:0]  dy_trig_ff;

   // Stage: length times trig magnitude
   logic [vsz_pkg::TRIG_MAG_W-1:0]     cos_mag;
   logic [vsz_pkg::TRIG_MAG_W-1:0]     sin_mag;
   logic [vsz_pkg::OFS_MAG_W-1:0]      ofs_x_ff;
   logic [vsz_pkg::OFS_MAG_W-1:0]      ofs_y_ff;
   logic                               neg_x_ff;
   logic                               neg_y_ff;
   logic signed [vsz_pkg::DIFF_W-1:0]  dx_mult_ff;
   logic signed [vsz_pkg::DIFF_W-1:0]  dy_mult_ff;

   // Stage: rounded half-length offset
   logic [vsz_pkg::OFS_MAG_W:0]        rnd_x;
   logic [vsz_pkg::OFS_MAG_W:0]        rnd_y;
   logic [vsz_pkg::HN_W-1:0]           qx;
   logic [vsz_pkg::HN_W-1:0]           qy;
   logic signed [vsz_pkg::HN_W-1:0]    hnx_in;
   logic signed [vsz_pkg::HN_W-1:0]    hny_in;
   logic signed [vsz_pkg::HN_W-1:0]    hnx_ff;
   logic signed [vsz_pkg::HN_W-1:0]    hny_ff;
   logic signed [vsz_pkg::DIFF_W-1:0]  dx_hn_ff;
   logic signed [vsz_pkg::DIFF_W-1:0]  dy_hn_ff;

   // Stage: head point to tested point
   logic signed [vsz_pkg::HM_W-1:0]    hmx_ff;
   logic signed [vsz_pkg::HM_W-1:0]    hmy_ff;
   logic signed [vsz_pkg::HN_W-1:0]    hnx_hm_ff;
   logic signed [vsz_pkg::HN_W-1:0]    hny_hm_ff;

   // Stage: products
   logic signed [vsz_pkg::PROD_W-1:0]  along_x_ff;
   logic signed [vsz_pkg::PROD_W-1:0]  along_y_ff;
   logic signed [vsz_pkg::PROD_W-1:0]  across_x_ff;
   logic signed [vsz_pkg::PROD_W-1:0]  across_y_ff;
   logic signed [vsz_pkg::HNN_W-1:0]   nx2_in;
   logic signed [vsz_pkg::HNN_W-1:0]   ny2_in;
   logic [vsz_pkg::HNN_W-1:0]          nx2_ff;
   logic [vsz_pkg::HNN_W-1:0]          ny2_ff;
   logic [vsz_pkg::SQ_W-1:0]           front_sq_ff;
   logic [vsz_pkg::SQ_W-1:0]           back_sq_ff;
   logic [vsz_pkg::SQ_W-1:0]           side_sq_prod_ff;

   // Stage: dot products and norm
   logic signed [vsz_pkg::DOT_W-1:0]   along_in;
   logic signed [vsz_pkg::DOT_W-1:0]   along_ff;
   logic signed [vsz_pkg::DOT_W-1:0]   across_ff;
   logic [vsz_pkg::HNN_W-1:0]          hnn_ff;
   logic [vsz_pkg::SQ_W-1:0]           along_msq_ff;
   logic [vsz_pkg::SQ_W-1:0]           side_sq_ff;

   // Square tests and result
   vsz_pkg::sq_adv_type                sq_adv;
   logic                               along_exc;
   logic                               across_exc;
   logic                               inside_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         car_length_ff <= vsz_pkg::CAR_LENGTH_RESET;
         front_margin_ff <= vsz_pkg::MARGIN_RESET;
         back_margin_ff <= vsz_pkg::MARGIN_RESET;
         side_margin_ff <= vsz_pkg::MARGIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            vsz_pkg::CSR_CAR_LENGTH: begin
               car_length_ff <= csr_wdata;
            end
            vsz_pkg::CSR_FRONT_MARGIN: begin
               front_margin_ff <= csr_wdata;
            end
            vsz_pkg::CSR_BACK_MARGIN: begin
               back_margin_ff <= csr_wdata;
            end
            vsz_pkg::CSR_SIDE_MARGIN: begin
               side_margin_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // A stage loads when it is empty or its content moves on
   always_comb begin
      load[vsz_pkg::PIPE_DEPTH-1] = !valid_ff[vsz_pkg::PIPE_DEPTH-1] || rsp_tready;
      for (int i = vsz_pkg::PIPE_DEPTH - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = load[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < vsz_pkg::PIPE_DEPTH; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = load[ST_IDX];
   assign in_acc = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   // Table index and differences
   always_comb begin
      point_x = req_tdata[0 +: vsz_pkg::COORD_W];
      point_y = req_tdata[vsz_pkg::COORD_W +: vsz_pkg::COORD_W];
      car_x = req_tdata[2*vsz_pkg::COORD_W +: vsz_pkg::COORD_W];
      car_y = req_tdata[3*vsz_pkg::COORD_W +: vsz_pkg::COORD_W];
      car_heading = req_tdata[4*vsz_pkg::COORD_W +: vsz_pkg::HEADING_W];
      head_scaled = 32'(car_heading) * 32'(vsz_pkg::SINE_TABLE_ENTRIES);
      dx_in = vsz_pkg::DIFF_W'(point_x) - vsz_pkg::DIFF_W'(car_x);
      dy_in = vsz_pkg::DIFF_W'(point_y) - vsz_pkg::DIFF_W'(car_y);
   end

   always_ff @(posedge clock) begin
      if (load[ST_IDX]) begin
         idx_ff <= head_scaled[vsz_pkg::HEADING_W +: vsz_pkg::TAB_IDX_W];
         dx_idx_ff <= dx_in;
         dy_idx_ff <= dy_in;
      end
   end

   // Table read
   always_ff @(posedge clock) begin
      if (load[ST_TRIG]) begin
         sin_ff <= vsz_pkg::SIN_TAB[idx_ff];
         cos_ff <= vsz_pkg::COS_TAB[idx_ff];
         dx_trig_ff <= dx_idx_ff;
         dy_trig_ff <= dy_idx_ff;
      end
   end

   // Length times trig magnitude, sign kept aside
   always_comb begin
      cos_mag = cos_ff[vsz_pkg::TRIG_W-1] ? vsz_pkg::TRIG_MAG_W'(-cos_ff)
                                          : vsz_pkg::TRIG_MAG_W'(cos_ff);
      sin_mag = sin_ff[vsz_pkg::TRIG_W-1] ? vsz_pkg::TRIG_MAG_W'(-sin_ff)
                                          : vsz_pkg::TRIG_MAG_W'(sin_ff);
   end

   always_ff @(posedge clock) begin
      if (load[ST_MULT]) begin
         ofs_x_ff <= vsz_pkg::OFS_MAG_W'(car_length_ff) * vsz_pkg::OFS_MAG_W'(cos_mag);
         ofs_y_ff <= vsz_pkg::OFS_MAG_W'(car_length_ff) * vsz_pkg::OFS_MAG_W'(sin_mag);
         neg_x_ff <= cos_ff[vsz_pkg::TRIG_W-1];
         neg_y_ff <= sin_ff[vsz_pkg::TRIG_W-1];
         dx_mult_ff <= dx_trig_ff;
         dy_mult_ff <= dy_trig_ff;
      end
   end

   // Round to nearest, ties away from zero, then restore sign
   always_comb begin
      rnd_x = (vsz_pkg::OFS_MAG_W + 1)'(ofs_x_ff) + HN_ROUND;
      rnd_y = (vsz_pkg::OFS_MAG_W + 1)'(ofs_y_ff) + HN_ROUND;
      qx = rnd_x[vsz_pkg::OFS_MAG_W:vsz_pkg::HN_SHIFT];
      qy = rnd_y[vsz_pkg::OFS_MAG_W:vsz_pkg::HN_SHIFT];
      hnx_in = neg_x_ff ? -qx : qx;
      hny_in = neg_y_ff ? -qy : qy;
   end

   always_ff @(posedge clock) begin
      if (load[ST_HN]) begin
         hnx_ff <= hnx_in;
         hny_ff <= hny_in;
         dx_hn_ff <= dx_mult_ff;
         dy_hn_ff <= dy_mult_ff;
      end
   end

   // Vector from the head point to the tested point
   always_ff @(posedge clock) begin
      if (load[ST_HM]) begin
         hmx_ff <= vsz_pkg::HM_W'(dx_hn_ff) - vsz_pkg::HM_W'(hnx_ff);
         hmy_ff <= vsz_pkg::HM_W'(dy_hn_ff) - vsz_pkg::HM_W'(hny_ff);
         hnx_hm_ff <= hnx_ff;
         hny_hm_ff <= hny_ff;
      end
   end

   // Products for the dot products, the norm and the margin squares
   always_comb begin
      nx2_in = vsz_pkg::HNN_W'(hnx_hm_ff) * vsz_pkg::HNN_W'(hnx_hm_ff);
      ny2_in = vsz_pkg::HNN_W'(hny_hm_ff) * vsz_pkg::HNN_W'(hny_hm_ff);
   end

   always_ff @(posedge clock) begin
      if (load[ST_PROD]) begin
         along_x_ff <= vsz_pkg::PROD_W'(hmx_ff) * vsz_pkg::PROD_W'(hnx_hm_ff);
         along_y_ff <= vsz_pkg::PROD_W'(hmy_ff) * vsz_pkg::PROD_W'(hny_hm_ff);
         across_x_ff <= vsz_pkg::PROD_W'(hmy_ff) * vsz_pkg::PROD_W'(hnx_hm_ff);
         across_y_ff <= vsz_pkg::PROD_W'(hmx_ff) * vsz_pkg::PROD_W'(hny_hm_ff);
         nx2_ff <= nx2_in;
         ny2_ff <= ny2_in;
         front_sq_ff <= vsz_pkg::SQ_W'(front_margin_ff) * vsz_pkg::SQ_W'(front_margin_ff);
         back_sq_ff <= vsz_pkg::SQ_W'(back_margin_ff) * vsz_pkg::SQ_W'(back_margin_ff);
         side_sq_prod_ff <= vsz_pkg::SQ_W'(side_margin_ff) * vsz_pkg::SQ_W'(side_margin_ff);
      end
   end

   // Sums; a zero projection never exceeds, so the sign alone picks front or back margin
   assign along_in = vsz_pkg::DOT_W'(along_x_ff) + vsz_pkg::DOT_W'(along_y_ff);

   always_ff @(posedge clock) begin
      if (load[ST_DOT]) begin
         along_ff <= along_in;
         across_ff <= vsz_pkg::DOT_W'(across_x_ff) - vsz_pkg::DOT_W'(across_y_ff);
         hnn_ff <= nx2_ff + ny2_ff;
         along_msq_ff <= along_in[vsz_pkg::DOT_W-1] ? back_sq_ff : front_sq_ff;
         side_sq_ff <= side_sq_prod_ff;
      end
   end

   assign sq_adv.load_mag = load[ST_SQA];
   assign sq_adv.load_sq = load[ST_SQB];

   vsz_sq_test u_along_test (
      .clock     (clock),
      .adv       (sq_adv),
      .value     (along_ff),
      .norm_sq   (hnn_ff),
      .margin_sq (along_msq_ff),
      .exceeds   (along_exc)
   );

   vsz_sq_test u_across_test (
      .clock     (clock),
      .adv       (sq_adv),
      .value     (across_ff),
      .norm_sq   (hnn_ff),
      .margin_sq (side_sq_ff),
      .exceeds   (across_exc)
   );

   always_ff @(posedge clock) begin
      if (load[ST_OUT]) begin
         inside_ff <= !(along_exc || across_exc);
      end
   end

   assign rsp_tvalid = valid_ff[ST_OUT];
   assign rsp_tdata = {(vsz_pkg::RSP_DATA_W - 1)'(0), inside_ff};

   // An empty output stage frees the whole chain
   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[ST_OUT] |-> req_tready)
      else $error("input stalled with empty output stage");

   // Transactions in flight change only by acceptances and deliveries
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(valid_ff) + int'($past(out_acc))
                == $past($countones(valid_ff)) + int'($past(in_acc))))
      else $error("transaction lost or duplicated in pipeline");

   // Rounded offset stays within half of the largest car length
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_HN] |-> (hnx_ff <= HN_LIMIT) && (hnx_ff >= -HN_LIMIT)
                          && (hny_ff <= HN_LIMIT) && (hny_ff >= -HN_LIMIT))
      else $error("head offset out of range");

   // Squared heading length fits the threshold multiplier
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_DOT] |-> hnn_ff <= HNN_LIMIT)
      else $error("heading norm out of range");

endmodule

`default_nettype wire

### tb/vehicle_safety_zone_check_unit_test.sv
// Self-checking testbench of the safety zone check: directed and random queries against a scoreboard model.
`timescale 1ns / 100ps

module vehicle_safety_zone_check_unit_test;

   import vsz_pkg::*;

   // One query as it travels on req_tdata; point_x sits in the lowest bits
   typedef struct packed {
      bit        [15:0] heading;
      bit signed [31:0] car_y;
      bit signed [31:0] car_x;
      bit signed [31:0] point_y;
      bit signed [31:0] point_x;
   } zone_query;

   typedef struct {
      zone_query query;
      bit        in_zone;
   } zone_answer;

   localparam bit [63:0] Q30 = 64'd1 << 30;
   localparam bit [63:0] QUARTER_TURN_Q30 = 64'd1686629713;   // pi/2 in Q30

   class zone_scoreboard;
      bit [15:0]  car_len;
      bit [15:0]  front_mgn;
      bit [15:0]  back_mgn;
      bit [15:0]  side_mgn;
      longint     sin_lut[SINE_TABLE_ENTRIES];
      longint     cos_lut[SINE_TABLE_ENTRIES];
      zone_answer pending[$];
      int         errors;
      int         answered;
      int         in_cnt;

      function new();
         bit [63:0] turn;
         car_len = CAR_LENGTH_RESET;
         front_mgn = MARGIN_RESET;
         back_mgn = MARGIN_RESET;
         side_mgn = MARGIN_RESET;
         for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
            turn = (64'(k) << 32) / 64'(SINE_TABLE_ENTRIES);
            sin_lut[k] = turn_sine(turn[31:0]);
            cos_lut[k] = turn_sine(turn[31:0] + 32'h4000_0000);
         end
      endfunction

      // Sine of a phase where 2^32 is a full turn, Q16, rounded and clipped at 1.0
      function longint turn_sine(bit [31:0] phase);
         bit [63:0] f;
         bit [63:0] x;
         bit [63:0] x2;
         bit [63:0] t;
         bit [63:0] s;
         bit [63:0] r;
         f = {34'd0, phase[29:0]};
         if (phase[30]) begin
            f = Q30 - f;
         end
         x = (f * QUARTER_TURN_Q30) >> 30;
         x2 = (x * x) >> 30;
         t = Q30 - x2 / 64'd110;
         t = Q30 - ((x2 * t) >> 30) / 64'd72;
         t = Q30 - ((x2 * t) >> 30) / 64'd42;
         t = Q30 - ((x2 * t) >> 30) / 64'd20;
         t = Q30 - ((x2 * t) >> 30) / 64'd6;
         s = (x * t) >> 30;
         r = (s + 64'd8192) >> 14;
         if (r > 64'd65536) begin
            r = 64'd65536;
         end
         return phase[31] ? -longint'(r) : longint'(r);
      endfunction

      // Half the car length along one axis, rounded half away from zero
      function longint half_length_offset(longint trig);
         bit [63:0] mag;
         longint    rounded;
         mag = 64'(car_len) * 64'(trig < 0 ? -trig : trig);
         rounded = longint'((mag + 64'd65536) >> 17);
         return trig < 0 ? -rounded : rounded;
      endfunction

      function bit square_above(longint a, bit [63:0] lim);
         bit [63:0] mag;
         mag = (a < 0) ? 64'(-a) : 64'(a);
         if (mag >= (64'd1 << 32)) begin
            return 1'b1;
         end
         return mag * mag > lim;
      endfunction

      function bit zone_contains(zone_query q);
         int        k;
         longint    hnx;
         longint    hny;
         longint    hmx;
         longint    hmy;
         longint    along;
         longint    across;
         bit [63:0] hnn;
         bit        hit;
         k = int'((64'(q.heading) * 64'(SINE_TABLE_ENTRIES)) >> 16);
         hnx = half_length_offset(cos_lut[k]);
         hny = half_length_offset(sin_lut[k]);
         hmx = longint'(q.point_x) - (longint'(q.car_x) + hnx);
         hmy = longint'(q.point_y) - (longint'(q.car_y) + hny);
         hnn = 64'(hnx * hnx + hny * hny);
         along = hmx * hnx + hmy * hny;
         across = hmy * hnx - hmx * hny;
         hit = 1'b1;
         if (along >= 0 && square_above(along, hnn * 64'(front_mgn) * 64'(front_mgn))) begin
            hit = 1'b0;
         end
         if (along <= 0 && square_above(along, hnn * 64'(back_mgn) * 64'(back_mgn))) begin
            hit = 1'b0;
         end
         if (square_above(across, hnn * 64'(side_mgn) * 64'(side_mgn))) begin
            hit = 1'b0;
         end
         return hit;
      endfunction

      function void set_reg(csr_index_type idx, bit [15:0] value);
         case (idx)
            CSR_CAR_LENGTH: begin
               car_len = value;
            end
            CSR_FRONT_MARGIN: begin
               front_mgn = value;
            end
            CSR_BACK_MARGIN: begin
               back_mgn = value;
            end
            CSR_SIDE_MARGIN: begin
               side_mgn = value;
            end
            default: begin
            end
         endcase
      endfunction

      function void note_query(zone_query q);
         zone_answer a;
         a.query = q;
         a.in_zone = zone_contains(q);
         pending.push_back(a);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_result(bit seen);
         zone_answer a;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("inside_zone %0b with no query outstanding", seen));
            return;
         end
         a = pending.pop_front();
         answered++;
         if (seen) begin
            in_cnt++;
         end
         if (seen !== a.in_zone) begin
            report_mismatch($sformatf(
               "inside_zone %0b, want %0b: point (%0d,%0d) car (%0d,%0d) heading 0x%04h",
               seen, a.in_zone, a.query.point_x, a.query.point_y, a.query.car_x,
               a.query.car_y, a.query.heading));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_CAR_LENGTH;
   logic [REG_W-1:0]      csr_wdata = '0;

   zone_scoreboard sb;
   bit             send_steady = 1'b0;
   bit             recv_steady = 1'b0;
   int             setting_cnt = 1;

   vehicle_safety_zone_check_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Watch every handshake and register write at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            sb.set_reg(csr_index_type'(csr_index), csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            sb.note_query(zone_query'(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata[0]);
         end
      end
   end

   function automatic zone_query make_query(int px, int py, int cx, int cy, bit [15:0] hd);
      zone_query q;
      q.point_x = px;
      q.point_y = py;
      q.car_x = cx;
      q.car_y = cy;
      q.heading = hd;
      return q;
   endfunction

   // Mostly points scattered around the car so both answers show up often
   function automatic zone_query random_query();
      zone_query q;
      bit [15:0] mgn;
      int        reach;
      int        pick;
      mgn = sb.front_mgn;
      if (sb.back_mgn > mgn) begin
         mgn = sb.back_mgn;
      end
      if (sb.side_mgn > mgn) begin
         mgn = sb.side_mgn;
      end
      reach = int'(sb.car_len) / 2 + int'(mgn) + 2;
      pick = $urandom_range(0, 9);
      q.heading = $urandom_range(0, 16'hFFFF);
      q.car_x = $urandom;
      q.car_y = $urandom;
      if (pick == 8) begin
         q.car_x = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 2 * reach)
                                        : 32'h8000_0000 + $urandom_range(0, 2 * reach);
         q.car_y = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 2 * reach)
                                        : 32'h8000_0000 + $urandom_range(0, 2 * reach);
      end
      if (pick == 7) begin
         q.point_x = $urandom;
         q.point_y = $urandom;
      end else if (pick == 9) begin
         q.point_x = q.car_x + (int'($urandom_range(0, 6)) - 3);
         q.point_y = q.car_y + (int'($urandom_range(0, 6)) - 3);
      end else begin
         q.point_x = q.car_x + (int'($urandom_range(0, 2 * reach)) - reach);
         q.point_y = q.car_y + (int'($urandom_range(0, 2 * reach)) - reach);
      end
      return q;
   endfunction

   // Enter and leave at a falling edge
   task automatic send_query(zone_query q);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= q;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_random(int count);
      repeat (count) send_query(random_query());
   endtask

   // Hold off the sender until every answer is back
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, bit [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic configure(bit [15:0] len, bit [15:0] fm, bit [15:0] bm, bit [15:0] sm);
      write_reg(CSR_CAR_LENGTH, len);
      write_reg(CSR_FRONT_MARGIN, fm);
      write_reg(CSR_BACK_MARGIN, bm);
      write_reg(CSR_SIDE_MARGIN, sm);
      csr_we <= 1'b0;
      setting_cnt++;
   endtask

   // Result side: random stall before each transaction, none while receiving steadily
   initial begin
      int stall;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = recv_steady ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      bit [15:0] len;
      bit [15:0] fm;
      bit [15:0] bm;
      bit [15:0] sm;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset registers: head point at half length, margins of one unit
      send_query(make_query(512, 0, 0, 0, 16'h0000));
      send_query(make_query(768, 0, 0, 0, 16'h0000));
      send_query(make_query(769, 0, 0, 0, 16'h0000));
      send_query(make_query(256, 0, 0, 0, 16'h0000));
      send_query(make_query(255, 0, 0, 0, 16'h0000));
      send_query(make_query(512, 256, 0, 0, 16'h0000));
      send_query(make_query(512, -256, 0, 0, 16'h0000));
      send_query(make_query(512, 257, 0, 0, 16'h0000));
      send_query(make_query(0, 0, 0, 0, 16'h0000));
      send_query(make_query(512, 0, 0, 0, 16'h003F));
      send_query(make_query(512, 0, 0, 0, 16'hFFFF));
      send_query(make_query(0, 512, 0, 0, 16'h4000));
      send_query(make_query(0, 768, 0, 0, 16'h4000));
      send_query(make_query(0, 769, 0, 0, 16'h4000));
      send_query(make_query(-768, 0, 0, 0, 16'h8000));
      send_query(make_query(-769, 0, 0, 0, 16'h8000));
      send_query(make_query(0, -512, 0, 0, 16'hC000));
      send_query(make_query(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 16'h0000));
      send_query(make_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            16'hAAAA));
      send_query(make_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            16'h5555));
      // Head point right at the edge of the coordinate range
      send_query(make_query(32'h7FFF_FFFF, 0, 32'h7FFF_FDFF, 0, 16'h0000));
      send_query(make_query(32'h8000_0000, 0, 32'h8000_0200, 0, 16'h8000));
      run_random(66);

      for (int phase = 1; phase < 8; phase++) begin
         case (phase)
            1: begin   // zero length: every point is inside
               len = 16'd0;
               fm = $urandom;
               bm = $urandom;
               sm = $urandom;
            end
            2: begin
               len = 16'hFFFF;
               fm = 16'hFFFF;
               bm = 16'hFFFF;
               sm = 16'hFFFF;
            end
            3: begin   // zero margins: only the head point itself is inside
               len = 16'd2048;
               fm = 16'd0;
               bm = 16'd0;
               sm = 16'd0;
            end
            4: begin
               len = $urandom_range(0, 4096);
               fm = $urandom_range(0, 1024);
               bm = $urandom_range(0, 1024);
               sm = $urandom_range(0, 1024);
            end
            5: begin
               len = 16'hFFFF;
               fm = $urandom_range(0, 4096);
               bm = $urandom_range(0, 4096);
               sm = $urandom_range(0, 4096);
            end
            6: begin
               len = $urandom;
               fm = $urandom;
               bm = $urandom;
               sm = $urandom;
            end
            default: begin
               len = $urandom_range(1, 512);
               fm = $urandom_range(0, 512);
               bm = $urandom_range(0, 512);
               sm = $urandom_range(0, 512);
            end
         endcase
         drain_pipeline();
         send_steady = (phase == 2 || phase == 5);
         recv_steady = (phase == 3 || phase == 5);
         configure(len, fm, bm, sm);
         if (phase == 3) begin
            send_query(make_query(2024, -1000, 1000, -1000, 16'h0000));
            send_query(make_query(2025, -1000, 1000, -1000, 16'h0000));
            send_query(make_query(2024, -999, 1000, -1000, 16'h0000));
         end
         run_random(66);
      end

      drain_pipeline();
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      $display("Covered %0d register settings including both extremes and zero length.",
               setting_cnt);
      $display("Checked %0d answers: %0d inside the zone, %0d outside, %0d mismatches.",
               sb.answered, sb.in_cnt, sb.answered - sb.in_cnt, sb.errors);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Timeout with %0d answers outstanding", sb.pending.size());
      $display("Verification failed");
      $finish;
   end

endmodule

### vehicle_safety_zone_check_unit.f
rtl/vsz_pkg.sv
rtl/vsz_sq_test.sv
rtl/vehicle_safety_zone_check_unit.sv
tb/vehicle_safety_zone_check_unit_test.sv
